>>> design/mip_pkg.sv
// ----------------------------------------------------------------------------
// mip_pkg
// Shared types and constants for the rgba mipmap box downsampler.
// ----------------------------------------------------------------------------
package mip_pkg;

  localparam int MAX_DIM_DEF    = 4096;
  localparam int MAX_LEVELS_DEF = 13;

  localparam int CH_W      = 8;
  localparam int LEVEL_W   = 4;
  localparam int COORD_W   = 11;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     BASE_RESET = 13'd4096;

  typedef struct packed {
    logic load;
    logic eval;
    logic acc;
    logic flush;
  } mip_cmd_t;

  typedef struct packed {
    logic stop;
    logic busy;
  } mip_sts_t;

  // lowest bits first: level, column, row, red, green, blue, alpha
  typedef struct packed {
    logic [CH_W-1:0]    alpha;
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    red;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [LEVEL_W-1:0] level;
  } mip_pix_t;

endpackage

>>> design/mip_ctrl.sv
// ----------------------------------------------------------------------------
// mip_ctrl
// Sequencer: accepts an item, walks the levels, flushes the last result.
// ----------------------------------------------------------------------------
module mip_ctrl
  import mip_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  mip_sts_t sts,
  output mip_cmd_t cmd
);

  typedef enum logic [1:0] {IDLE, LVL, ACC, FLUSH} state_t;

  state_t state;

  always_comb begin
    cmd       = '0;
    s_tready  = (state == IDLE);
    cmd.load  = (state == IDLE) && s_tvalid;
    cmd.eval  = (state == LVL);
    cmd.acc   = (state == ACC);
    cmd.flush = (state == FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) state <= LVL;
        end
        LVL: begin
          state <= sts.stop ? FLUSH : ACC;
        end
        ACC: begin
          if (!sts.busy) state <= LVL;
        end
        FLUSH: begin
          if (!sts.busy) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> design/mip_dp.sv
// ----------------------------------------------------------------------------
// mip_dp
// Datapath: level positions, pair sums, column sum memory, result registers.
// ----------------------------------------------------------------------------
module mip_dp
  import mip_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser,
  input  mip_cmd_t             cmd,
  output mip_sts_t             sts
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int PW = $clog2(MAX_DIM);
  localparam int OW = DW + 1;
  localparam int LW = $clog2(MAX_LEVELS);
  localparam int SW = CH_W + 1;
  localparam int MW = 4 * SW;
  localparam int XW = DW + CFG_W;

  logic [CFG_W-1:0] base_width, base_height;
  logic [DW-1:0]    w, h, dw_r, dh_r;
  logic [OW-1:0]    off;
  logic [LW-1:0]    lv;
  logic [CH_W-1:0]  v [4];
  logic [SW-1:0]    vsum [4];
  logic [PW-1:0]    cx_r, cy_r;
  logic             fy2_r, done_r;
  logic [1:0]       shift_r;
  logic [PW-1:0]    pos_x [MAX_LEVELS];
  logic [PW-1:0]    pos_y [MAX_LEVELS];
  logic [CH_W-1:0]  hsum [MAX_LEVELS][4];
  logic [MW-1:0]    mem [MAX_DIM];
  logic [MW-1:0]    rdata;
  mip_pix_t         hold, out_pix, new_pix;
  logic             hold_valid, hold_done;

  logic [DW-1:0] clamp_w, clamp_h, dw, dh, wlim, hlim;
  logic [PW-1:0] xw, yw, cx, cy;
  logic [PW:0]   nx, ny;
  logic [OW-1:0] idx_sum, idx;
  logic [SW-1:0] vh [4];
  logic [SW:0]   tot [4];
  logic [SW:0]   shv [4];
  logic [CH_W-1:0] res [4];
  logic fx2, fy2, one, top, trail, hstore, cstore, act, proc;
  logic mem_we, mem_re, busy, out_go, step;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] val);
    logic [DW-1:0] r;
    if (val == '0) r = DW'(1);
    else if (XW'(val) > XW'(MAX_DIM)) r = DW'(MAX_DIM);
    else r = DW'(val);
    return r;
  endfunction

  always_comb begin
    clamp_w = clamp_dim(base_width);
    clamp_h = clamp_dim(base_height);
    xw      = pos_x[lv];
    yw      = pos_y[lv];
    fx2     = (w >= DW'(2));
    fy2     = (h >= DW'(2));
    dw      = fx2 ? (w >> 1) : w;
    dh      = fy2 ? (h >> 1) : h;
    wlim    = fx2 ? (dw << 1) : w;
    hlim    = fy2 ? (dh << 1) : h;
    one     = (w == DW'(1)) && (h == DW'(1));
    top     = (lv == LW'(MAX_LEVELS - 1));
    trail   = (DW'(xw) >= wlim) || (DW'(yw) >= hlim);
    hstore  = fx2 && !xw[0];
    cstore  = fy2 && !yw[0];
    cx      = fx2 ? (xw >> 1) : xw;
    cy      = fy2 ? (yw >> 1) : yw;
    idx_sum = off + OW'(cx);
    idx     = (idx_sum >= OW'(MAX_DIM)) ? idx_sum - OW'(MAX_DIM) : idx_sum;
    nx      = {1'b0, xw} + (PW+1)'(1);
    ny      = {1'b0, yw} + (PW+1)'(1);
    for (int c = 0; c < 4; c++) begin
      vh[c]  = SW'(v[c]) + (fx2 ? SW'(hsum[lv][c]) : SW'(0));
      tot[c] = {1'b0, vsum[c]} + (fy2_r ? {1'b0, rdata[c*SW +: SW]} : (SW+1)'(0));
      shv[c] = tot[c] >> shift_r;
      res[c] = shv[c][CH_W-1:0];
    end
    act      = cmd.eval && !one && !top;
    proc     = act && !trail;
    mem_we   = proc && !hstore && cstore;
    mem_re   = proc && !hstore && !cstore && fy2;
    busy     = hold_valid && m_tvalid && !m_tready;
    out_go   = (cmd.acc || cmd.flush) && !busy && hold_valid;
    step     = cmd.acc && !busy;
    sts.stop = one || top || trail || hstore || cstore;
    sts.busy = busy;
    new_pix.level  = LEVEL_W'({1'b0, lv} + (LW+1)'(1));
    new_pix.column = COORD_W'(cx_r);
    new_pix.row    = COORD_W'(cy_r);
    new_pix.red    = res[0];
    new_pix.green  = res[1];
    new_pix.blue   = res[2];
    new_pix.alpha  = res[3];
    m_tdata = OUT_W'(out_pix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_width  <= BASE_RESET;
      base_height <= BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  base_width  <= cfg_data;
        REG_HEIGHT: base_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        pos_x[i] <= '0;
        pos_y[i] <= '0;
      end
    end else if (act) begin
      if (OW'(nx) >= OW'(w)) begin
        pos_x[lv] <= '0;
        pos_y[lv] <= (OW'(ny) >= OW'(h)) ? '0 : ny[PW-1:0];
      end else begin
        pos_x[lv] <= nx[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx[PW-1:0]] <= {vh[3], vh[2], vh[1], vh[0]};
    if (mem_re) rdata <= mem[idx[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < 4; c++) v[c] <= s_tdata[c*CH_W +: CH_W];
      lv  <= '0;
      w   <= clamp_w;
      h   <= clamp_h;
      off <= '0;
    end
    if (proc && hstore) begin
      for (int c = 0; c < 4; c++) hsum[lv][c] <= v[c];
    end
    if (proc && !hstore && !cstore) begin
      vsum    <= vh;
      cx_r    <= cx;
      cy_r    <= cy;
      fy2_r   <= fy2;
      dw_r    <= dw;
      dh_r    <= dh;
      shift_r <= {1'b0, fx2} + {1'b0, fy2};
      done_r  <= (dw == DW'(1)) && (dh == DW'(1));
    end
    if (step) begin
      hold      <= new_pix;
      hold_done <= done_r;
      for (int c = 0; c < 4; c++) v[c] <= res[c];
      lv  <= lv + LW'(1);
      w   <= dw_r;
      h   <= dh_r;
      off <= off + OW'(dw_r);
    end
    if (out_go) begin
      out_pix <= hold;
      m_tlast <= cmd.flush;
      m_tuser <= hold_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_go) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (step) hold_valid <= 1'b1;
      else if (cmd.flush && !busy) hold_valid <= 1'b0;
    end
  end

  a_lv_range: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> (32'(lv) < MAX_LEVELS))
    else $error("level index out of range");

  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !mem_re)
    else $error("column memory read and write together");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush && !busy) |=> !hold_valid)
    else $error("held result survived flush");

  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    step |=> hold_valid)
    else $error("emitted result not held");

endmodule

>>> design/rgba_mipmap_box_downsampler.sv
// ----------------------------------------------------------------------------
// rgba_mipmap_box_downsampler
// 2x2 box filter mip chain builder over a raster stream of rgba8 pixels.
// ----------------------------------------------------------------------------
// sequence: an item is accepted in the idle state; each level that emits a
// result runs a position update and column memory access, then average and
// hand-off; the level that ends the walk emits nothing and is followed by a
// flush. the next item is accepted after the flush; a stalled output adds its
// wait.
// reset clears level positions, restores 4096x4096, memory is not cleared.
module rgba_mipmap_box_downsampler
  import mip_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // red, green, blue, alpha
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // level, column, row, red, green, blue, alpha
  output logic                 m_tlast,
  output logic                 m_tuser    // chain_done
);

  mip_cmd_t cmd;
  mip_sts_t sts;

  mip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mip_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
